@@ rtl/core/aib_pkg.sv @@
package aib_pkg;

   localparam int WORD_W        = 32;
   localparam int PROD_W        = 64;
   localparam int SUM_W         = 66;
   localparam int FRAC_BITS_DEF = 16;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   // values that ride along with an item through the reciprocal pipeline
   typedef struct packed {
      word_type m11;
      word_type m12;
      word_type m21;
      word_type m22;
      word_type m31;
      word_type m32;
      word_type wmin_x;
      word_type wmin_y;
      word_type wmax_x;
      word_type wmax_y;
      logic     ok;
      logic     neg;
   } side_type;

   function automatic logic fits_word(input sum_type v);
      return (&v[SUM_W-1:WORD_W-1]) | ~(|v[SUM_W-1:WORD_W-1]);
   endfunction

endpackage

@@ rtl/core/aib_req_if.sv @@
interface aib_req_if;
   logic              valid;
   logic              ready;
   aib_pkg::word_type m11;
   aib_pkg::word_type m12;
   aib_pkg::word_type m21;
   aib_pkg::word_type m22;
   aib_pkg::word_type m31;
   aib_pkg::word_type m32;
   aib_pkg::word_type min_x;
   aib_pkg::word_type min_y;
   aib_pkg::word_type max_x;
   aib_pkg::word_type max_y;

   modport source (output valid, m11, m12, m21, m22, m31, m32, min_x, min_y, max_x, max_y,
                   input ready);
   modport sink (input valid, m11, m12, m21, m22, m31, m32, min_x, min_y, max_x, max_y,
                 output ready);
endinterface

@@ rtl/core/aib_rsp_if.sv @@
interface aib_rsp_if;
   logic              valid;
   logic              ready;
   logic              valid_res;
   aib_pkg::word_type inv_a;
   aib_pkg::word_type inv_c;
   aib_pkg::word_type inv_tx;
   aib_pkg::word_type inv_b;
   aib_pkg::word_type inv_d;
   aib_pkg::word_type inv_ty;
   aib_pkg::word_type world_min_x;
   aib_pkg::word_type world_min_y;
   aib_pkg::word_type world_max_x;
   aib_pkg::word_type world_max_y;

   modport source (output valid, valid_res, inv_a, inv_c, inv_tx, inv_b, inv_d, inv_ty,
                   world_min_x, world_min_y, world_max_x, world_max_y, input ready);
   modport sink (input valid, valid_res, inv_a, inv_c, inv_tx, inv_b, inv_d, inv_ty,
                 world_min_x, world_min_y, world_max_x, world_max_y, output ready);
endinterface

@@ rtl/core/aib_recip_div.sv @@
// Pipelined restoring divider: quotient of 2^(2F) by an unsigned divisor,
// one quotient bit per stage.
module aib_recip_div #(
   parameter int FRAC_BITS = aib_pkg::FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic [aib_pkg::WORD_W-1:0] in_divisor,
   input  aib_pkg::side_type        in_side,
   output logic                     out_valid,
   output logic [2*FRAC_BITS:0]     out_quot,
   output aib_pkg::side_type        out_side
);
   localparam int Q_W = 2*FRAC_BITS+1;
   localparam int R_W = aib_pkg::WORD_W+1;

   logic                       valid_ff [Q_W];
   logic [R_W-1:0]             rem_ff   [Q_W];
   logic [Q_W-1:0]             quot_ff  [Q_W];
   logic [aib_pkg::WORD_W-1:0] div_ff   [Q_W];
   aib_pkg::side_type          side_ff  [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic                       src_valid;
      logic [R_W-1:0]             src_rem;
      logic [Q_W-1:0]             src_quot;
      logic [aib_pkg::WORD_W-1:0] src_div;
      aib_pkg::side_type          src_side;
      logic [R_W-1:0]             shifted;
      logic                       take;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = '0;
         assign src_quot  = '0;
         assign src_div   = in_divisor;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_quot  = quot_ff[k-1];
         assign src_div   = div_ff[k-1];
         assign src_side  = side_ff[k-1];
      end

      // the dividend has a single one bit, at its top
      assign shifted = {src_rem[R_W-2:0], 1'(k == 0)};
      assign take    = shifted >= {1'b0, src_div};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= src_valid;
         end
         if (advance) begin
            rem_ff[k]  <= take ? shifted - {1'b0, src_div} : shifted;
            quot_ff[k] <= {src_quot[Q_W-2:0], take};
            div_ff[k]  <= src_div;
            side_ff[k] <= src_side;
         end
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign out_quot  = quot_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];
endmodule

@@ rtl/core/affine_inverse_and_box_bounds.sv @@
// Channel  Dir  Handshake     Payload
// req_ch   in   valid/ready   m11 m12 m21 m22 m31 m32 min_x min_y max_x max_y
// rsp_ch   out  valid/ready   valid_res inv_a inv_c inv_tx inv_b inv_d inv_ty world bounds
//
// One request per cycle while no response waits on rsp_ch.ready; the default format is Q16.16.
// The reciprocal divider resolves one quotient bit per stage.
// Reset clears only the stage valid bits.
// The whole pipeline holds while a response waits on rsp_ch.ready; req_ch.ready
// follows the same advance condition.
module affine_inverse_and_box_bounds #(
   parameter int FRAC_BITS = aib_pkg::FRAC_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   aib_req_if.sink    req_ch,
   aib_rsp_if.source  rsp_ch
);
   localparam int Q_W  = 2*FRAC_BITS+1;
   localparam int SW   = aib_pkg::SUM_W;
   localparam int WW   = aib_pkg::WORD_W;

   logic advance;
   logic rsp_valid_ff;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   // ---------------- stage 1: products
   logic                s1_valid_ff;
   aib_pkg::side_type   s1_side_ff, s1_side_in;
   aib_pkg::prod_type   s1_pda_ff, s1_pdb_ff;
   aib_pkg::prod_type   s1_px11_ff [2];
   aib_pkg::prod_type   s1_py21_ff [2];
   aib_pkg::prod_type   s1_px12_ff [2];
   aib_pkg::prod_type   s1_py22_ff [2];

   always_comb begin
      s1_side_in        = '0;
      s1_side_in.m11    = req_ch.m11;
      s1_side_in.m12    = req_ch.m12;
      s1_side_in.m21    = req_ch.m21;
      s1_side_in.m22    = req_ch.m22;
      s1_side_in.m31    = req_ch.m31;
      s1_side_in.m32    = req_ch.m32;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_ch.valid;
      end
      if (advance) begin
         s1_side_ff    <= s1_side_in;
         s1_pda_ff     <= req_ch.m11 * req_ch.m22;
         s1_pdb_ff     <= req_ch.m12 * req_ch.m21;
         s1_px11_ff[0] <= req_ch.min_x * req_ch.m11;
         s1_px11_ff[1] <= req_ch.max_x * req_ch.m11;
         s1_py21_ff[0] <= req_ch.min_y * req_ch.m21;
         s1_py21_ff[1] <= req_ch.max_y * req_ch.m21;
         s1_px12_ff[0] <= req_ch.min_x * req_ch.m12;
         s1_px12_ff[1] <= req_ch.max_x * req_ch.m12;
         s1_py22_ff[0] <= req_ch.min_y * req_ch.m22;
         s1_py22_ff[1] <= req_ch.max_y * req_ch.m22;
      end
   end

   // ---------------- stage 2: determinant and corners
   logic                s2_valid_ff;
   aib_pkg::side_type   s2_side_ff;
   aib_pkg::word_type   s2_det_ff;
   logic                s2_det_ok_ff, s2_det_ok_in;
   aib_pkg::word_type   s2_wx_ff [4];
   aib_pkg::word_type   s2_wy_ff [4];
   aib_pkg::word_type   s2_wx_in [4];
   aib_pkg::word_type   s2_wy_in [4];
   logic                s2_corner_ok_ff, s2_corner_ok_in;
   aib_pkg::sum_type    s2_det_sum;
   aib_pkg::sum_type    s2_det_shift;

   always_comb begin
      aib_pkg::sum_type sx, sy;
      s2_det_sum      = SW'(s1_pda_ff) - SW'(s1_pdb_ff);
      s2_det_shift    = s2_det_sum >>> FRAC_BITS;
      s2_det_ok_in    = aib_pkg::fits_word(s2_det_shift) && (s2_det_shift != '0);
      s2_corner_ok_in = 1'b1;
      for (int i = 0; i < 4; i++) begin
         sx = SW'(s1_px11_ff[i/2]) + SW'(s1_py21_ff[i%2]);
         sx = (sx >>> FRAC_BITS) + SW'(s1_side_ff.m31);
         sy = SW'(s1_px12_ff[i/2]) + SW'(s1_py22_ff[i%2]);
         sy = (sy >>> FRAC_BITS) + SW'(s1_side_ff.m32);
         s2_wx_in[i] = sx[WW-1:0];
         s2_wy_in[i] = sy[WW-1:0];
         s2_corner_ok_in = s2_corner_ok_in & aib_pkg::fits_word(sx) & aib_pkg::fits_word(sy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_side_ff      <= s1_side_ff;
         s2_det_ff       <= s2_det_shift[WW-1:0];
         s2_det_ok_ff    <= s2_det_ok_in;
         s2_wx_ff        <= s2_wx_in;
         s2_wy_ff        <= s2_wy_in;
         s2_corner_ok_ff <= s2_corner_ok_in;
      end
   end

   // ---------------- stage 3: bounds and divisor magnitude
   logic                s3_valid_ff;
   aib_pkg::side_type   s3_side_ff, s3_side_in;
   logic [WW-1:0]       s3_div_ff;

   always_comb begin
      aib_pkg::word_type lo_x, hi_x, lo_y, hi_y;
      lo_x = s2_wx_ff[0];
      hi_x = s2_wx_ff[0];
      lo_y = s2_wy_ff[0];
      hi_y = s2_wy_ff[0];
      for (int i = 1; i < 4; i++) begin
         if (s2_wx_ff[i] < lo_x) lo_x = s2_wx_ff[i];
         if (s2_wx_ff[i] > hi_x) hi_x = s2_wx_ff[i];
         if (s2_wy_ff[i] < lo_y) lo_y = s2_wy_ff[i];
         if (s2_wy_ff[i] > hi_y) hi_y = s2_wy_ff[i];
      end
      s3_side_in        = s2_side_ff;
      s3_side_in.wmin_x = lo_x;
      s3_side_in.wmax_x = hi_x;
      s3_side_in.wmin_y = lo_y;
      s3_side_in.wmax_y = hi_y;
      s3_side_in.ok     = s2_det_ok_ff & s2_corner_ok_ff;
      s3_side_in.neg    = s2_det_ff[WW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_side_ff <= s3_side_in;
         s3_div_ff  <= s2_det_ff[WW-1] ? WW'(-s2_det_ff) : WW'(s2_det_ff);
      end
   end

   // ---------------- reciprocal
   logic                dv_valid;
   logic [Q_W-1:0]      dv_quot;
   aib_pkg::side_type   dv_side;

   aib_recip_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (s3_valid_ff),
      .in_divisor (s3_div_ff),
      .in_side    (s3_side_ff),
      .out_valid  (dv_valid),
      .out_quot   (dv_quot),
      .out_side   (dv_side)
   );

   // ---------------- stage A: sign the reciprocal, inverse products
   logic                sa_valid_ff;
   aib_pkg::side_type   sa_side_ff, sa_side_in;
   aib_pkg::prod_type   sa_pa_ff, sa_pb_ff, sa_pc_ff, sa_pd_ff;
   aib_pkg::word_type   sa_recip;
   logic                sa_recip_ok;

   always_comb begin
      logic [aib_pkg::PROD_W-1:0] q_wide;
      q_wide      = aib_pkg::PROD_W'(dv_quot);
      sa_recip    = dv_side.neg ? -q_wide[WW-1:0] : q_wide[WW-1:0];
      sa_recip_ok = dv_side.neg ? (q_wide <= (64'd1 << (WW-1)))
                                : (q_wide <  (64'd1 << (WW-1)));
      sa_side_in    = dv_side;
      sa_side_in.ok = dv_side.ok & sa_recip_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
      end else if (advance) begin
         sa_valid_ff <= dv_valid;
      end
      if (advance) begin
         sa_side_ff <= sa_side_in;
         sa_pa_ff   <= dv_side.m22 * sa_recip;
         sa_pb_ff   <= -(dv_side.m12 * sa_recip);
         sa_pc_ff   <= -(dv_side.m21 * sa_recip);
         sa_pd_ff   <= dv_side.m11 * sa_recip;
      end
   end

   // ---------------- stage B: scale inverse entries
   logic                sb_valid_ff;
   aib_pkg::side_type   sb_side_ff, sb_side_in;
   aib_pkg::word_type   sb_a_ff, sb_b_ff, sb_c_ff, sb_d_ff;
   aib_pkg::sum_type    sb_a, sb_b, sb_c, sb_d;

   always_comb begin
      sb_a = SW'(sa_pa_ff) >>> FRAC_BITS;
      sb_b = SW'(sa_pb_ff) >>> FRAC_BITS;
      sb_c = SW'(sa_pc_ff) >>> FRAC_BITS;
      sb_d = SW'(sa_pd_ff) >>> FRAC_BITS;
      sb_side_in    = sa_side_ff;
      sb_side_in.ok = sa_side_ff.ok & aib_pkg::fits_word(sb_a) & aib_pkg::fits_word(sb_b)
                    & aib_pkg::fits_word(sb_c) & aib_pkg::fits_word(sb_d);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_valid_ff <= 1'b0;
      end else if (advance) begin
         sb_valid_ff <= sa_valid_ff;
      end
      if (advance) begin
         sb_side_ff <= sb_side_in;
         sb_a_ff    <= sb_a[WW-1:0];
         sb_b_ff    <= sb_b[WW-1:0];
         sb_c_ff    <= sb_c[WW-1:0];
         sb_d_ff    <= sb_d[WW-1:0];
      end
   end

   // ---------------- stage C: translation products
   logic                sc_valid_ff;
   aib_pkg::side_type   sc_side_ff;
   aib_pkg::word_type   sc_a_ff, sc_b_ff, sc_c_ff, sc_d_ff;
   aib_pkg::prod_type   sc_xa_ff, sc_yc_ff, sc_xb_ff, sc_yd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_valid_ff <= 1'b0;
      end else if (advance) begin
         sc_valid_ff <= sb_valid_ff;
      end
      if (advance) begin
         sc_side_ff <= sb_side_ff;
         sc_a_ff    <= sb_a_ff;
         sc_b_ff    <= sb_b_ff;
         sc_c_ff    <= sb_c_ff;
         sc_d_ff    <= sb_d_ff;
         sc_xa_ff   <= sb_side_ff.m31 * sb_a_ff;
         sc_yc_ff   <= sb_side_ff.m32 * sb_c_ff;
         sc_xb_ff   <= sb_side_ff.m31 * sb_b_ff;
         sc_yd_ff   <= sb_side_ff.m32 * sb_d_ff;
      end
   end

   // ---------------- output register
   aib_pkg::sum_type    sd_tx, sd_ty;
   logic                sd_ok;
   logic                valid_res_ff;
   aib_pkg::word_type   inv_a_ff, inv_b_ff, inv_c_ff, inv_d_ff, inv_tx_ff, inv_ty_ff;
   aib_pkg::word_type   wmin_x_ff, wmin_y_ff, wmax_x_ff, wmax_y_ff;

   always_comb begin
      sd_tx = -(SW'(sc_xa_ff) + SW'(sc_yc_ff));
      sd_tx = sd_tx >>> FRAC_BITS;
      sd_ty = -(SW'(sc_xb_ff) + SW'(sc_yd_ff));
      sd_ty = sd_ty >>> FRAC_BITS;
      sd_ok = sc_side_ff.ok & aib_pkg::fits_word(sd_tx) & aib_pkg::fits_word(sd_ty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= sc_valid_ff;
      end
      if (advance) begin
         // drop every field to zero on a failed item
         valid_res_ff <= sd_ok;
         inv_a_ff     <= sd_ok ? sc_a_ff : '0;
         inv_b_ff     <= sd_ok ? sc_b_ff : '0;
         inv_c_ff     <= sd_ok ? sc_c_ff : '0;
         inv_d_ff     <= sd_ok ? sc_d_ff : '0;
         inv_tx_ff    <= sd_ok ? sd_tx[WW-1:0] : '0;
         inv_ty_ff    <= sd_ok ? sd_ty[WW-1:0] : '0;
         wmin_x_ff    <= sd_ok ? sc_side_ff.wmin_x : '0;
         wmin_y_ff    <= sd_ok ? sc_side_ff.wmin_y : '0;
         wmax_x_ff    <= sd_ok ? sc_side_ff.wmax_x : '0;
         wmax_y_ff    <= sd_ok ? sc_side_ff.wmax_y : '0;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.valid_res   = valid_res_ff;
   assign rsp_ch.inv_a       = inv_a_ff;
   assign rsp_ch.inv_c       = inv_c_ff;
   assign rsp_ch.inv_tx      = inv_tx_ff;
   assign rsp_ch.inv_b       = inv_b_ff;
   assign rsp_ch.inv_d       = inv_d_ff;
   assign rsp_ch.inv_ty      = inv_ty_ff;
   assign rsp_ch.world_min_x = wmin_x_ff;
   assign rsp_ch.world_min_y = wmin_y_ff;
   assign rsp_ch.world_max_x = wmax_x_ff;
   assign rsp_ch.world_max_y = wmax_y_ff;
endmodule

@@ verif/affine_inverse_and_box_bounds_tb.sv @@
`timescale 1ns / 100ps

module affine_inverse_and_box_bounds_tb;

   localparam int F       = aib_pkg::FRAC_BITS_DEF;
   localparam int LATENCY = 2 * F + 8;
   localparam int N_RAND  = 750;

   typedef struct {
      aib_pkg::word_type m11, m12, m21, m22, m31, m32, min_x, min_y, max_x, max_y;
   } xform_req_type;

   typedef struct packed {
      logic              valid_res;
      aib_pkg::word_type inv_a, inv_c, inv_tx, inv_b, inv_d, inv_ty;
      aib_pkg::word_type wmin_x, wmin_y, wmax_x, wmax_y;
   } xform_rsp_type;

   typedef struct {
      xform_req_type req;
      logic          has_exp;
      xform_rsp_type exp;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   int   errors = 0;
   int   n_sent = 0;
   int   n_checked = 0;
   int   n_valid = 0;
   int   n_invalid = 0;
   bit   calm = 0;

   aib_req_if req_ch ();
   aib_rsp_if rsp_ch ();

   affine_inverse_and_box_bounds dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always #10 clock = ~clock;

   xform_rsp_type pending_rsp[$];

   // exact floor division by 2^F on wide signed values
   function automatic logic signed [131:0] fshift(input logic signed [131:0] v);
      return v >>> F;
   endfunction

   function automatic logic in_word(input logic signed [131:0] v);
      return v >= -(132'sd1 <<< 31) && v <= ((132'sd1 <<< 31) - 1);
   endfunction

   function automatic xform_rsp_type predict_inverse_bounds(input xform_req_type r);
      xform_rsp_type o;
      logic signed [131:0] m11, m12, m21, m22, m31, m32, det, recip;
      logic signed [131:0] a, b, c, d, tx, ty, wx, wy;
      logic signed [131:0] xs[4], ys[4];
      logic signed [131:0] mnx, mny, mxx, mxy;
      logic ok;
      m11 = r.m11; m12 = r.m12; m21 = r.m21; m22 = r.m22; m31 = r.m31; m32 = r.m32;
      o = '{default: '0};
      mnx = 0; mny = 0; mxx = 0; mxy = 0;
      a = 0; b = 0; c = 0; d = 0; tx = 0; ty = 0;
      det = fshift(m11 * m22 - m12 * m21);
      ok = in_word(det) && det != 0;
      if (ok) begin
         recip = (132'sd1 <<< (2 * F)) / det;
         ok = in_word(recip);
         if (ok) begin
            a = fshift(m22 * recip);
            b = fshift(-m12 * recip);
            c = fshift(-m21 * recip);
            d = fshift(m11 * recip);
            ok = in_word(a) && in_word(b) && in_word(c) && in_word(d);
         end
      end
      if (ok) begin
         tx = fshift(-(m31 * a) - m32 * c);
         ty = fshift(-(m31 * b) - m32 * d);
         ok = in_word(tx) && in_word(ty);
      end
      if (ok) begin
         xs[0] = r.min_x; xs[1] = r.max_x; xs[2] = r.max_x; xs[3] = r.min_x;
         ys[0] = r.min_y; ys[1] = r.min_y; ys[2] = r.max_y; ys[3] = r.max_y;
         for (int i = 0; i < 4 && ok; i++) begin
            wx = fshift(xs[i] * m11 + ys[i] * m21) + m31;
            wy = fshift(xs[i] * m12 + ys[i] * m22) + m32;
            if (!in_word(wx) || !in_word(wy)) ok = 0;
            else if (i == 0) begin
               mnx = wx; mxx = wx; mny = wy; mxy = wy;
            end else begin
               if (wx < mnx) mnx = wx;
               if (wx > mxx) mxx = wx;
               if (wy < mny) mny = wy;
               if (wy > mxy) mxy = wy;
            end
         end
      end
      if (ok) begin
         o.valid_res = 1;
         o.inv_a = a[31:0]; o.inv_b = b[31:0]; o.inv_c = c[31:0]; o.inv_d = d[31:0];
         o.inv_tx = tx[31:0]; o.inv_ty = ty[31:0];
         o.wmin_x = mnx[31:0]; o.wmin_y = mny[31:0];
         o.wmax_x = mxx[31:0]; o.wmax_y = mxy[31:0];
      end
      return o;
   endfunction

   function automatic aib_pkg::word_type rand_word(input int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 8 << F)) - (4 << F);
         2: return $signed($urandom_range(0, 512 << F)) - (256 << F);
         default: return $signed($urandom_range(0, 1 << (F + 1))) - (1 << F);
      endcase
   endfunction

   function automatic xform_req_type rand_req();
      xform_req_type r;
      int mode;
      mode = $urandom_range(0, 9);
      // keep most matrices small so that inversion succeeds
      if (mode < 7) begin
         r.m11 = rand_word(1); r.m12 = rand_word(1);
         r.m21 = rand_word(1); r.m22 = rand_word(1);
         r.m31 = rand_word(2); r.m32 = rand_word(2);
         r.min_x = rand_word(2); r.min_y = rand_word(2);
         r.max_x = rand_word(2); r.max_y = rand_word(2);
         if ($urandom_range(0, 9) == 0) begin
            r.m21 = 0; r.m12 = 0;
         end
      end else if (mode < 9) begin
         r.m11 = rand_word(3); r.m12 = rand_word(3);
         r.m21 = rand_word(3); r.m22 = rand_word(3);
         r.m31 = rand_word(0); r.m32 = rand_word(0);
         r.min_x = rand_word(0); r.min_y = rand_word(0);
         r.max_x = rand_word(0); r.max_y = rand_word(0);
      end else begin
         r.m11 = rand_word(0); r.m12 = rand_word(0);
         r.m21 = rand_word(0); r.m22 = rand_word(0);
         r.m31 = rand_word(0); r.m32 = rand_word(0);
         r.min_x = rand_word(0); r.min_y = rand_word(0);
         r.max_x = rand_word(0); r.max_y = rand_word(0);
      end
      return r;
   endfunction

   function automatic xform_req_type mk(input aib_pkg::word_type a11, a12, a21, a22, t1, t2,
                                        x0, y0, x1, y1);
      xform_req_type r;
      r.m11 = a11; r.m12 = a12; r.m21 = a21; r.m22 = a22; r.m31 = t1; r.m32 = t2;
      r.min_x = x0; r.min_y = y0; r.max_x = x1; r.max_y = y1;
      return r;
   endfunction

   function automatic bit idle_now();
      return !calm && $urandom_range(0, 99) < 12;
   endfunction

   // valid stays high between back-to-back requests; drop it only while idling
   task automatic send_request(input xform_req_type r);
      while (idle_now()) begin
         req_ch.valid <= 0;
         @(negedge clock);
      end
      req_ch.valid <= 1;
      req_ch.m11 <= r.m11; req_ch.m12 <= r.m12; req_ch.m21 <= r.m21;
      req_ch.m22 <= r.m22; req_ch.m31 <= r.m31; req_ch.m32 <= r.m32;
      req_ch.min_x <= r.min_x; req_ch.min_y <= r.min_y;
      req_ch.max_x <= r.max_x; req_ch.max_y <= r.max_y;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // model queue on the accepting edge
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         pending_rsp = {pending_rsp, predict_inverse_bounds(mk(req_ch.m11, req_ch.m12,
            req_ch.m21, req_ch.m22, req_ch.m31, req_ch.m32, req_ch.min_x,
            req_ch.min_y, req_ch.max_x, req_ch.max_y))};
         n_sent++;
      end
   end

   task automatic check_field(input string nm, input logic [31:0] e, input logic [31:0] a);
      if (e !== a) begin
         $display("%0t mismatch %s expected %h actual %h", $time, nm, e, a);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      xform_rsp_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected response valid_res %b", $time, rsp_ch.valid_res);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            n_checked++;
            if (e.valid_res) n_valid++; else n_invalid++;
            check_field("valid_res", 32'(e.valid_res), 32'(rsp_ch.valid_res));
            check_field("inv_a", e.inv_a, rsp_ch.inv_a);
            check_field("inv_c", e.inv_c, rsp_ch.inv_c);
            check_field("inv_tx", e.inv_tx, rsp_ch.inv_tx);
            check_field("inv_b", e.inv_b, rsp_ch.inv_b);
            check_field("inv_d", e.inv_d, rsp_ch.inv_d);
            check_field("inv_ty", e.inv_ty, rsp_ch.inv_ty);
            check_field("world_min_x", e.wmin_x, rsp_ch.world_min_x);
            check_field("world_min_y", e.wmin_y, rsp_ch.world_min_y);
            check_field("world_max_x", e.wmax_x, rsp_ch.world_max_x);
            check_field("world_max_y", e.wmax_y, rsp_ch.world_max_y);
         end
      end
   end

   always @(negedge clock) rsp_ch.ready <= !idle_now();

   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      xform_rsp_type zero_rsp, exp_now;
      aib_pkg::word_type one, big, neg;
      int spin;
      one = 1 << F;
      big = 32'sh7fffffff;
      neg = 32'sh80000000;
      zero_rsp = '{default: '0};
      req_ch.valid = 0;
      req_ch.m11 = 0; req_ch.m12 = 0; req_ch.m21 = 0; req_ch.m22 = 0;
      req_ch.m31 = 0; req_ch.m32 = 0;
      req_ch.min_x = 0; req_ch.min_y = 0; req_ch.max_x = 0; req_ch.max_y = 0;
      rsp_ch.ready = 0;

      // identity, unit box: inverse is identity and bounds equal the box
      row.req = mk(one, 0, 0, one, 0, 0, 0, 0, one, one);
      row.has_exp = 1;
      row.exp = '{1, one, 0, 0, 0, one, 0, 0, 0, one, one};
      rows = {rows, row};
      // singular: all zero, and rank one
      row.has_exp = 1; row.exp = zero_rsp;
      row.req = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0); rows = {rows, row};
      row.req = mk(one, one, one, one, 5, 5, 0, 0, one, one); rows = {rows, row};
      // extremes overflow the determinant; tiny or all -1 entries make it zero
      row.req = mk(big, big, neg, big, big, neg, neg, neg, big, big); rows = {rows, row};
      row.req = mk(neg, 0, 0, neg, 0, 0, 0, 0, 0, 0); rows = {rows, row};
      row.req = mk(1, 0, 0, 1, 0, 0, 0, 0, 0, 0); rows = {rows, row};
      row.req = mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1); rows = {rows, row};
      // remaining rows go through the predictor
      row.has_exp = 0;
      row.req = mk(one, 0, 0, one, big, neg, 0, 0, one, one); rows = {rows, row};
      row.req = mk(one, 0, 0, one, 0, 0, neg, neg, big, big); rows = {rows, row};
      row.req = mk(2 * one, one, -one, 3 * one, 7 * one, -3 * one,
                   -one, -2 * one, 4 * one, 5 * one); rows = {rows, row};
      row.req = mk(-one, 0, 0, -one, 0, 0, 3 * one, 3 * one, -one, -one);
      rows = {rows, row}; // inverted box
      row.req = mk(0, one, -one, 0, one, one, -one, -one, one, one); rows = {rows, row};
      row.req = mk(one >>> 4, 0, 0, one >>> 4, 0, 0, 0, 0, one, one); rows = {rows, row};
      row.req = mk(256 * one, 0, 0, 256 * one, 0, 0, 0, 0, one, one); rows = {rows, row};
      row.req = mk(one, 0, 0, one, 32'sh40000000, 0, 0, 0, 32'sh40000000, 0);
      rows = {rows, row};
      row.req = mk(3, 5, 7, 11, 13, 17, 19, 23, 29, 31); rows = {rows, row};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (rows[k]) begin
         if (rows[k].has_exp) begin
            exp_now = predict_inverse_bounds(rows[k].req);
            if (exp_now != rows[k].exp) begin
               $display("%0t directed row %0d table value disagrees with predictor",
                        $time, k);
               errors++;
            end
         end
         send_request(rows[k].req);
      end

      for (int n = 0; n < N_RAND; n++) begin
         calm = (n >= 300 && n < 400);
         if (n == 150 || n == 500) begin
            // hold until the pipeline has drained
            req_ch.valid <= 0;
            @(negedge clock);
            while (pending_rsp.size() != 0) @(negedge clock);
         end
         send_request(rand_req());
      end
      calm = 0;
      req_ch.valid <= 0;

      spin = 0;
      while (pending_rsp.size() != 0 && spin < 100000) begin
         @(negedge clock);
         spin++;
      end
      repeat (LATENCY + 10) @(negedge clock);
      if (pending_rsp.size() != 0) begin
         $display("%0t %0d responses never arrived", $time, pending_rsp.size());
         errors++;
      end
      $display("Sent %0d requests, checked %0d responses (%0d invertible, %0d rejected)",
               n_sent, n_checked, n_valid, n_invalid);
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
